### src/prbe_pkg.sv
// ----------------------------------------------------------------------------
// prbe_pkg
// shared types and constants for the path rtt and bandwidth estimator
// ----------------------------------------------------------------------------
package prbe_pkg;

	localparam int RTT_W      = 31;
	localparam int BYTES_W    = 32;
	localparam int IVAL_W     = 32;
	localparam int RATE_W     = 52;
	localparam int US_W       = 20;
	localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;

	// operation decided by the front end
	typedef enum logic [1:0] {
		OP_RTT  = 2'd0,
		OP_BW   = 2'd1,
		OP_SKIP = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [RTT_W-1:0]   rtt_sample;
		logic [BYTES_W-1:0] bytes;
		logic [IVAL_W-1:0]  interval;
	} cmd_t;

endpackage

### src/prbe_front.sv
// ----------------------------------------------------------------------------
// prbe_front
// accepts input words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module prbe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [prbe_pkg::RTT_W-1:0]    sample_rtt,
	input  logic [prbe_pkg::BYTES_W-1:0]  delivered_bytes,
	input  logic [prbe_pkg::IVAL_W-1:0]   delivery_interval,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output prbe_pkg::cmd_t                cmd
);

	prbe_pkg::cmd_t entries_q [2];
	prbe_pkg::cmd_t new_cmd;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	// zero interval never touches state, so it skips the back end's work
	always_comb begin
		new_cmd.rtt_sample = sample_rtt;
		new_cmd.bytes      = delivered_bytes;
		new_cmd.interval   = delivery_interval;
		if (!kind) begin
			new_cmd.op = prbe_pkg::OP_RTT;
		end else if (delivery_interval == '0) begin
			new_cmd.op = prbe_pkg::OP_SKIP;
		end else begin
			new_cmd.op = prbe_pkg::OP_BW;
		end
	end

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entries_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### src/prbe_div.sv
// ----------------------------------------------------------------------------
// prbe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module prbe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [prbe_pkg::RATE_W-1:0]   dividend,
	input  logic [prbe_pkg::IVAL_W-1:0]   divisor,
	output logic                          done,
	output logic [prbe_pkg::RATE_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(prbe_pkg::RATE_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(prbe_pkg::RATE_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [prbe_pkg::IVAL_W:0]     rem_q;
	logic [prbe_pkg::RATE_W-1:0]   quo_q;
	logic [prbe_pkg::IVAL_W-1:0]   div_q;
	logic [prbe_pkg::IVAL_W:0]     trial;
	logic [prbe_pkg::IVAL_W:0]     div_ext;
	logic                          fits;

	// remainder stays below the divisor, so the shifted trial fits one bit wider
	assign trial   = {rem_q[prbe_pkg::IVAL_W-1:0], quo_q[prbe_pkg::RATE_W-1]};
	assign div_ext = {1'b0, div_q};
	assign fits    = (trial >= div_ext);

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - div_ext) : trial;
			quo_q <= {quo_q[prbe_pkg::RATE_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_STEP;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

endmodule

### src/prbe_back.sv
// ----------------------------------------------------------------------------
// prbe_back
// carries out rtt and delivery updates and holds the result word
// ----------------------------------------------------------------------------
module prbe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  prbe_pkg::cmd_t                cmd,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prbe_pkg::RTT_W-1:0]    smoothed_rtt,
	output logic [prbe_pkg::RTT_W-1:0]    rtt_deviation,
	output logic [prbe_pkg::RTT_W-1:0]    minimum_rtt,
	output logic [prbe_pkg::RATE_W-1:0]   bandwidth_estimate
);

	localparam int RW = prbe_pkg::RTT_W;
	localparam int BW = prbe_pkg::RATE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RTT_DEV,
		ST_RTT_UPD,
		ST_MUL,
		ST_DIV,
		ST_BW,
		ST_PUSH
	} state_t;

	state_t                  state_q;
	prbe_pkg::cmd_t          cmd_q;
	logic [RW-1:0]           srtt_q;
	logic [RW-1:0]           rttvar_q;
	logic [RW-1:0]           rtt_min_q;
	logic [BW-1:0]           bw_q;
	logic [RW-1:0]           dev_q;
	logic [BW-1:0]           prod_q;
	logic                    div_start_q;
	logic                    div_done;
	logic [BW-1:0]           rate;
	logic                    out_valid_q;
	logic [RW-1:0]           out_srtt_q;
	logic [RW-1:0]           out_var_q;
	logic [RW-1:0]           out_min_q;
	logic [BW-1:0]           out_bw_q;
	logic [RW:0]             var_sum;
	logic [RW:0]             srtt_sum;
	logic [BW+3:0]           bw_sum;
	logic                    out_free;

	prbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (cmd_q.interval),
		.done     (div_done),
		.quotient (rate)
	);

	// each gain term truncated on its own
	assign var_sum  = {1'b0, rttvar_q} - {3'b0, rttvar_q[RW-1:2]} + {3'b0, dev_q[RW-1:2]};
	assign srtt_sum = {1'b0, srtt_q} - {4'b0, srtt_q[RW-1:3]}
		+ {4'b0, cmd_q.rtt_sample[RW-1:3]};
	// old*7 + new, the eighth taken by dropping three bits
	assign bw_sum   = {1'b0, bw_q, 3'b0} - {4'b0, bw_q} + {4'b0, rate};

	assign cmd_ready          = (state_q == ST_IDLE);
	assign out_free           = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign smoothed_rtt       = out_srtt_q;
	assign rtt_deviation      = out_var_q;
	assign minimum_rtt        = out_min_q;
	assign bandwidth_estimate = out_bw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			srtt_q      <= '0;
			rttvar_q    <= '0;
			rtt_min_q   <= '0;
			bw_q        <= '0;
			dev_q       <= '0;
			prod_q      <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_srtt_q  <= '0;
			out_var_q   <= '0;
			out_min_q   <= '0;
			out_bw_q    <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.op)
							prbe_pkg::OP_RTT: state_q <= ST_RTT_DEV;
							prbe_pkg::OP_BW:  state_q <= ST_MUL;
							default:          state_q <= ST_PUSH;
						endcase
					end
				end
				ST_RTT_DEV: begin
					dev_q <= (cmd_q.rtt_sample >= srtt_q) ? (cmd_q.rtt_sample - srtt_q)
						: (srtt_q - cmd_q.rtt_sample);
					state_q <= ST_RTT_UPD;
				end
				ST_RTT_UPD: begin
					if (srtt_q == '0) begin
						srtt_q   <= cmd_q.rtt_sample;
						rttvar_q <= {1'b0, cmd_q.rtt_sample[RW-1:1]};
					end else begin
						srtt_q   <= srtt_sum[RW-1:0];
						rttvar_q <= var_sum[RW-1:0];
					end
					if (rtt_min_q == '0 || cmd_q.rtt_sample < rtt_min_q) begin
						rtt_min_q <= cmd_q.rtt_sample;
					end
					state_q <= ST_PUSH;
				end
				ST_MUL: begin
					prod_q      <= BW'(cmd_q.bytes) * BW'(prbe_pkg::US_PER_SEC);
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BW;
					end
				end
				ST_BW: begin
					if (bw_q == '0) begin
						bw_q <= rate;
					end else begin
						bw_q <= bw_sum[BW+2:3];
					end
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_srtt_q  <= srtt_q;
						out_var_q   <= rttvar_q;
						out_min_q   <= rtt_min_q;
						out_bw_q    <= bw_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### src/path_rtt_bandwidth_estimator.sv
// ----------------------------------------------------------------------------
// path_rtt_bandwidth_estimator
// per-path smoothed rtt, rtt variance, minimum rtt and delivery rate
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one sample word: kind 0 is an
//   rtt sample, kind 1 a delivery sample (bytes over an interval)
//   output channel (out_valid / out_ready) returns one word per input word
//   with all four estimates after that word's update
//   a delivery word with a nonzero interval goes through the 52-step
//   bit-serial divider that forms bytes*1000000/interval, an rtt word or
//   a zero-interval word does not
//   the back end takes one word at a time; a two-word queue in the front
//   end keeps in_ready high until it holds two words
//   reset (arst_n low) clears every estimate to zero and empties the queue
//   when out_ready stays low, the result word holds in the output register,
//   the back end then waits with its next result and the queue fills up
//   before in_ready drops
// ----------------------------------------------------------------------------
module path_rtt_bandwidth_estimator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [prbe_pkg::RTT_W-1:0]    sample_rtt,
	input  logic [prbe_pkg::BYTES_W-1:0]  delivered_bytes,
	input  logic [prbe_pkg::IVAL_W-1:0]   delivery_interval,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prbe_pkg::RTT_W-1:0]    smoothed_rtt,
	output logic [prbe_pkg::RTT_W-1:0]    rtt_deviation,
	output logic [prbe_pkg::RTT_W-1:0]    minimum_rtt,
	output logic [prbe_pkg::RATE_W-1:0]   bandwidth_estimate
);

	// classified word between front and back
	prbe_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_ready;

	// front: accept and classify, queue up to two words
	prbe_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.kind              (kind),
		.sample_rtt        (sample_rtt),
		.delivered_bytes   (delivered_bytes),
		.delivery_interval (delivery_interval),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.cmd               (cmd)
	);

	// back: estimator state, divider and output register
	prbe_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd_valid          (cmd_valid),
		.cmd_ready          (cmd_ready),
		.cmd                (cmd),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.smoothed_rtt       (smoothed_rtt),
		.rtt_deviation      (rtt_deviation),
		.minimum_rtt        (minimum_rtt),
		.bandwidth_estimate (bandwidth_estimate)
	);

endmodule
